FILE: sv/bfm_pkg.sv
// ----------------------------------------------------------------------------
// bfm_pkg: shared types and constants of the bilinear force map
// Command and status codes, fixed field widths and the saturation helper.
// ----------------------------------------------------------------------------
package bfm_pkg;

    localparam logic [1:0] CMD_EVAL   = 2'd0;
    localparam logic [1:0] CMD_WR_DEF = 2'd1;
    localparam logic [1:0] CMD_WR_VEL = 2'd2;
    localparam logic [1:0] CMD_WR_TAB = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TOO_FEW = 2'd1;
    localparam logic [1:0] ST_EQUAL   = 2'd2;
    localparam logic [1:0] ST_SAT     = 2'd3;

    localparam logic [1:0] REG_NUM_DEF = 2'd0;
    localparam logic [1:0] REG_NUM_VEL = 2'd1;
    localparam logic [1:0] REG_PRELOAD = 2'd2;

    // Divider: numerator is a 34-bit difference scaled by 2^16, the
    // denominator a 33-bit difference. Only 31 quotient bits are resolved,
    // larger magnitudes saturate anyway.
    localparam int NUM_W   = 50;
    localparam int DEN_W   = 33;
    localparam int QB      = 31;
    localparam int DIV_LAT = QB + 2;
    localparam logic [QB-1:0] WLIM = QB'(1) << 30;

    typedef struct packed {
        logic               en;
        logic [3:0]         idx;
        logic signed [31:0] data;
    } axis_wr_t;

    typedef struct packed {
        logic               sat;
        logic signed [31:0] val;
    } sat_t;

    function automatic sat_t sat32(input logic signed [63:0] v);
        sat_t r;
        if (v > 64'sd2147483647) begin
            r.sat = 1'b1;
            r.val = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r.sat = 1'b1;
            r.val = 32'sh80000000;
        end else begin
            r.sat = 1'b0;
            r.val = v[31:0];
        end
        return r;
    endfunction

endpackage

FILE: sv/bfm_ram.sv
// ----------------------------------------------------------------------------
// bfm_ram: generic single-write, single-read RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module bfm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/bfm_div.sv
// ----------------------------------------------------------------------------
// bfm_div: pipelined signed divider for interpolation weights
// Restoring division, one quotient bit per stage, truncating toward zero,
// with the result saturated to plus or minus 2^30.
// ----------------------------------------------------------------------------
module bfm_div import bfm_pkg::*; (
    input  logic                    aclk,
    input  logic                    en,
    input  logic signed [NUM_W-1:0] num,
    input  logic signed [DEN_W-1:0] den,
    output logic signed [31:0]      quot,
    output logic                    sat
);

    logic [63:0]      rem_reg [QB+1];
    logic [DEN_W-1:0] dm_reg  [QB+1];
    logic [QB-1:0]    q_reg   [QB+1];
    logic             neg_reg [QB+1];
    logic             ovf_reg [QB+1];
    logic signed [31:0] quot_reg;
    logic               sat_reg;

    logic [NUM_W-1:0] an;
    logic [DEN_W-1:0] dm;

    assign an = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    assign dm = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= 64'(an);
            dm_reg[0]  <= dm;
            q_reg[0]   <= '0;
            neg_reg[0] <= num[NUM_W-1] ^ den[DEN_W-1];
            // A quotient of 2^31 or more is past any weight limit.
            ovf_reg[0] <= 64'(an) >= (64'(dm) << QB);
        end
    end

    for (genvar j = 1; j <= QB; j++) begin : g_step
        localparam int K = QB - j;
        logic [63:0]   sub;
        logic [63:0]   rem_next;
        logic [QB-1:0] q_next;

        assign sub = 64'(dm_reg[j-1]) << K;

        always_comb begin
            if (rem_reg[j-1] >= sub) begin
                rem_next = rem_reg[j-1] - sub;
                q_next   = q_reg[j-1] | (QB'(1) << K);
            end else begin
                rem_next = rem_reg[j-1];
                q_next   = q_reg[j-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j] <= rem_next;
                dm_reg[j]  <= dm_reg[j-1];
                q_reg[j]   <= q_next;
                neg_reg[j] <= neg_reg[j-1];
                ovf_reg[j] <= ovf_reg[j-1];
            end
        end
    end

    logic          big;
    logic [QB-1:0] mag;

    assign big = ovf_reg[QB] || (q_reg[QB] > WLIM);
    assign mag = big ? WLIM : q_reg[QB];

    always_ff @(posedge aclk) begin
        if (en) begin
            quot_reg <= neg_reg[QB] ? -$signed(32'(mag)) : $signed(32'(mag));
            sat_reg  <= big;
        end
    end

    assign quot = quot_reg;
    assign sat  = sat_reg;

endmodule

FILE: sv/bfm_axis.sv
// ----------------------------------------------------------------------------
// bfm_axis: breakpoint store and bracket search for one axis
// Holds the breakpoints, compares them all against the coordinate in
// parallel and registers the upper bracket as a one-hot vector.
// ----------------------------------------------------------------------------
module bfm_axis import bfm_pkg::*; #(
    parameter int N = 16,
    localparam int IW = $clog2(N),
    localparam int CW = $clog2(N + 1)
) (
    input  logic               aclk,
    input  logic               en,
    input  axis_wr_t           wr,
    input  logic signed [32:0] coord,
    input  logic [4:0]         count,
    output logic signed [31:0] b_lo,
    output logic signed [31:0] b_hi,
    output logic [IW-1:0]      i_lo,
    output logic [IW-1:0]      i_hi
);

    logic signed [31:0] bp_reg [N];
    logic [N-1:0]       hi_oh_reg;
    logic [N-1:0]       hi_oh_next;
    logic [N-1:0]       ge;
    logic [N-1:0]       last;
    logic [N-1:0]       first;
    logic [CW-1:0]      nc;

    assign nc = (32'(count) > N) ? CW'(N) : CW'(count);

    // Writes land here, in the same stage that reads the breakpoints, so
    // items keep their order.
    always_ff @(posedge aclk) begin
        if (en && wr.en) begin
            for (int i = 0; i < N; i++) begin
                if (32'(wr.idx) == i) begin
                    bp_reg[i] <= wr.data;
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < N; i++) begin
            ge[i]   = (i < 32'(nc)) && (33'(bp_reg[i]) >= coord);
            last[i] = (i + 1 == 32'(nc));
        end
        first = ge & (~ge + N'(1));
        hi_oh_next = (ge == '0) ? last : first;
        if (hi_oh_next[0]) begin
            hi_oh_next = N'(2);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hi_oh_reg <= hi_oh_next;
        end
    end

    logic [N-1:0] lo_oh;
    assign lo_oh = hi_oh_reg >> 1;

    always_comb begin
        b_lo = '0;
        b_hi = '0;
        i_lo = '0;
        i_hi = '0;
        for (int i = 0; i < N; i++) begin
            if (lo_oh[i]) begin
                b_lo = b_lo | bp_reg[i];
                i_lo = i_lo | IW'(i);
            end
            if (hi_oh_reg[i]) begin
                b_hi = b_hi | bp_reg[i];
                i_hi = i_hi | IW'(i);
            end
        end
    end

endmodule

FILE: sv/bilinear_force_map.sv
// ----------------------------------------------------------------------------
// bilinear_force_map: two-dimensional force map with bilinear interpolation
// Loads breakpoints and table entries, and answers evaluate beats with the
// preload minus the interpolated table force.
//
//  Channel  Ports                Contents
//  input    s_tvalid/tready      tuser: cmd; tdata: indices, value, coords
//  result   m_tvalid/tready      tuser: status; tdata: force_res
//  config   cfg_wr_en/index      num_def_points, num_vel_points, preload
//
// One beat enters every cycle unless the result port stalls.
// The latency is set mainly by the weight divider, one quotient bit a stage.
// Reset clears the valid bits and the configuration registers only.
// A stall at the result port holds the whole pipeline, including the memory
// read registers, so no beat is lost or repeated.
// ----------------------------------------------------------------------------
module bilinear_force_map import bfm_pkg::*; #(
    parameter int MAX_DEF_POINTS = 16,
    parameter int MAX_VEL_POINTS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // def_index[3:0], vel_index[7:4], write_value[39:8], length[71:40],
    // rest_len[103:72], velocity[135:104]
    input  logic [135:0] s_tdata,
    // cmd[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // force_res[31:0]
    output logic [31:0]  m_tdata,
    // status[1:0]
    output logic [1:0]   m_tuser,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_wdata
);

    localparam int DIW   = $clog2(MAX_DEF_POINTS);
    localparam int VIW   = $clog2(MAX_VEL_POINTS);
    localparam int DEPTH = MAX_DEF_POINTS * MAX_VEL_POINTS;
    localparam int TAW   = $clog2(DEPTH);

    typedef struct packed {
        logic [1:0]         cmd;
        logic [1:0]         st;
        logic               calc;
        logic [3:0]         di;
        logic [3:0]         vi;
        logic signed [31:0] wv;
        logic [DIW-1:0]     d_lo;
        logic [DIW-1:0]     d_hi;
        logic [VIW-1:0]     v_lo;
        logic [VIW-1:0]     v_hi;
    } side_t;

    logic en;

    // Configuration registers.
    logic [4:0]         num_def_reg;
    logic [4:0]         num_vel_reg;
    logic signed [31:0] preload_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_def_reg <= '0;
            num_vel_reg <= '0;
            preload_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_NUM_DEF: num_def_reg <= cfg_wdata[4:0];
                REG_NUM_VEL: num_vel_reg <= cfg_wdata[4:0];
                REG_PRELOAD: preload_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic too_few;
    assign too_few = (32'(num_def_reg) < 2) || (32'(num_vel_reg) < 2);

    // Stage A: registered input beat and deformation.
    logic               a_valid_reg;
    logic [1:0]         a_cmd_reg;
    logic [3:0]         a_di_reg;
    logic [3:0]         a_vi_reg;
    logic signed [31:0] a_wv_reg;
    logic signed [32:0] a_x_reg;
    logic signed [31:0] a_vel_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_cmd_reg <= s_tuser;
            a_di_reg  <= s_tdata[3:0];
            a_vi_reg  <= s_tdata[7:4];
            a_wv_reg  <= s_tdata[39:8];
            a_x_reg   <= 33'($signed(s_tdata[71:40])) - 33'($signed(s_tdata[103:72]));
            a_vel_reg <= s_tdata[135:104];
        end
    end

    axis_wr_t def_wr;
    axis_wr_t vel_wr;

    assign def_wr = '{en: a_valid_reg && (a_cmd_reg == CMD_WR_DEF), idx: a_di_reg,
                      data: a_wv_reg};
    assign vel_wr = '{en: a_valid_reg && (a_cmd_reg == CMD_WR_VEL), idx: a_vi_reg,
                      data: a_wv_reg};

    logic signed [31:0] bd_lo, bd_hi, bv_lo, bv_hi;
    logic [DIW-1:0]     id_lo, id_hi;
    logic [VIW-1:0]     iv_lo, iv_hi;

    bfm_axis #(.N(MAX_DEF_POINTS)) u_def_axis (
        .aclk  (aclk),
        .en    (en),
        .wr    (def_wr),
        .coord (a_x_reg),
        .count (num_def_reg),
        .b_lo  (bd_lo),
        .b_hi  (bd_hi),
        .i_lo  (id_lo),
        .i_hi  (id_hi)
    );

    bfm_axis #(.N(MAX_VEL_POINTS)) u_vel_axis (
        .aclk  (aclk),
        .en    (en),
        .wr    (vel_wr),
        .coord (33'(a_vel_reg)),
        .count (num_vel_reg),
        .b_lo  (bv_lo),
        .b_hi  (bv_hi),
        .i_lo  (iv_lo),
        .i_hi  (iv_hi)
    );

    // Stage B: bracket values, differences and divider operands.
    logic               b_valid_reg;
    logic [1:0]         b_cmd_reg;
    logic [3:0]         b_di_reg;
    logic [3:0]         b_vi_reg;
    logic signed [31:0] b_wv_reg;
    logic signed [32:0] b_x_reg;
    logic signed [31:0] b_vel_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (en) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_cmd_reg <= a_cmd_reg;
            b_di_reg  <= a_di_reg;
            b_vi_reg  <= a_vi_reg;
            b_wv_reg  <= a_wv_reg;
            b_x_reg   <= a_x_reg;
            b_vel_reg <= a_vel_reg;
        end
    end

    logic signed [DEN_W-1:0] dd, dv;
    logic signed [33:0]      nd_lo, nd_hi, nv_lo, nv_hi;
    side_t                   b_side;

    assign dd    = 33'(bd_hi) - 33'(bd_lo);
    assign dv    = 33'(bv_hi) - 33'(bv_lo);
    assign nd_lo = 34'(bd_hi) - 34'(b_x_reg);
    assign nd_hi = 34'(b_x_reg) - 34'(bd_lo);
    assign nv_lo = 34'(bv_hi) - 34'(b_vel_reg);
    assign nv_hi = 34'(b_vel_reg) - 34'(bv_lo);

    always_comb begin
        b_side.cmd  = b_cmd_reg;
        b_side.di   = b_di_reg;
        b_side.vi   = b_vi_reg;
        b_side.wv   = b_wv_reg;
        b_side.d_lo = id_lo;
        b_side.d_hi = id_hi;
        b_side.v_lo = iv_lo;
        b_side.v_hi = iv_hi;
        b_side.calc = 1'b0;
        if (b_cmd_reg != CMD_EVAL) begin
            b_side.st = ST_OK;
        end else if (too_few) begin
            b_side.st = ST_TOO_FEW;
        end else if (dd == '0 || dv == '0) begin
            b_side.st = ST_EQUAL;
        end else begin
            b_side.st   = ST_OK;
            b_side.calc = 1'b1;
        end
    end

    // Weight dividers, with the side band delayed to match.
    logic signed [31:0] wd1, wd2, wv1, wv2;
    logic               s_wd1, s_wd2, s_wv1, s_wv2;

    bfm_div u_div_d1 (.aclk(aclk), .en(en), .num($signed({nd_lo, 16'd0})), .den(dd),
                      .quot(wd1), .sat(s_wd1));
    bfm_div u_div_d2 (.aclk(aclk), .en(en), .num($signed({nd_hi, 16'd0})), .den(dd),
                      .quot(wd2), .sat(s_wd2));
    bfm_div u_div_v1 (.aclk(aclk), .en(en), .num($signed({nv_lo, 16'd0})), .den(dv),
                      .quot(wv1), .sat(s_wv1));
    bfm_div u_div_v2 (.aclk(aclk), .en(en), .num($signed({nv_hi, 16'd0})), .den(dv),
                      .quot(wv2), .sat(s_wv2));

    side_t side_reg  [DIV_LAT];
    logic  sv_valid_reg [DIV_LAT];

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= b_side;
            for (int i = 1; i < DIV_LAT; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DIV_LAT; i++) begin
                sv_valid_reg[i] <= 1'b0;
            end
        end else if (en) begin
            sv_valid_reg[0] <= b_valid_reg;
            for (int i = 1; i < DIV_LAT; i++) begin
                sv_valid_reg[i] <= sv_valid_reg[i-1];
            end
        end
    end

    // Table access: writes and reads share this stage so that order holds.
    side_t           r_side;
    logic            tab_we;
    logic [TAW-1:0]  tab_waddr;
    logic [TAW-1:0]  ra11, ra21, ra12, ra22;
    logic [31:0]     t11, t21, t12, t22;

    assign r_side    = side_reg[DIV_LAT-1];
    assign tab_we    = en && sv_valid_reg[DIV_LAT-1] && (r_side.cmd == CMD_WR_TAB)
                       && (32'(r_side.di) < MAX_DEF_POINTS)
                       && (32'(r_side.vi) < MAX_VEL_POINTS);
    assign tab_waddr = TAW'(32'(r_side.vi) * MAX_DEF_POINTS + 32'(r_side.di));
    assign ra11 = TAW'(32'(r_side.v_lo) * MAX_DEF_POINTS + 32'(r_side.d_lo));
    assign ra21 = TAW'(32'(r_side.v_hi) * MAX_DEF_POINTS + 32'(r_side.d_lo));
    assign ra12 = TAW'(32'(r_side.v_lo) * MAX_DEF_POINTS + 32'(r_side.d_hi));
    assign ra22 = TAW'(32'(r_side.v_hi) * MAX_DEF_POINTS + 32'(r_side.d_hi));

    bfm_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_tab11 (
        .aclk(aclk), .wr_en(tab_we), .wr_addr(tab_waddr), .wr_data(r_side.wv),
        .rd_en(en), .rd_addr(ra11), .rd_data(t11));
    bfm_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_tab21 (
        .aclk(aclk), .wr_en(tab_we), .wr_addr(tab_waddr), .wr_data(r_side.wv),
        .rd_en(en), .rd_addr(ra21), .rd_data(t21));
    bfm_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_tab12 (
        .aclk(aclk), .wr_en(tab_we), .wr_addr(tab_waddr), .wr_data(r_side.wv),
        .rd_en(en), .rd_addr(ra12), .rd_data(t12));
    bfm_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_tab22 (
        .aclk(aclk), .wr_en(tab_we), .wr_addr(tab_waddr), .wr_data(r_side.wv),
        .rd_en(en), .rd_addr(ra22), .rd_data(t22));

    // Interpolation stages P1 to P5.
    logic [4:0] p_valid_reg;
    logic [1:0] p_st_reg   [5];
    logic       p_calc_reg [5];
    logic       p_sat_reg  [5];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= '0;
        end else if (en) begin
            p_valid_reg <= {p_valid_reg[3:0], sv_valid_reg[DIV_LAT-1]};
        end
    end

    logic signed [31:0] p1_wd1_reg, p1_wd2_reg, p1_wv1_reg, p1_wv2_reg;
    logic signed [31:0] p2_wd1_reg, p2_wd2_reg;
    logic signed [63:0] p2_m11_reg, p2_m21_reg, p2_m12_reg, p2_m22_reg;
    logic signed [31:0] p3_wd1_reg, p3_wd2_reg;
    logic signed [31:0] p3_f1_reg, p3_f2_reg;
    logic signed [63:0] p4_m1_reg, p4_m2_reg;
    logic signed [31:0] p5_f_reg;

    sat_t f1_s, f2_s, f_s, res_s;

    assign f1_s  = sat32((p2_m11_reg + p2_m21_reg) >>> 16);
    assign f2_s  = sat32((p2_m12_reg + p2_m22_reg) >>> 16);
    assign f_s   = sat32((p4_m1_reg + p4_m2_reg) >>> 16);
    assign res_s = sat32(64'(33'(preload_reg) - 33'(p5_f_reg)));

    always_ff @(posedge aclk) begin
        if (en) begin
            p_st_reg[0]   <= r_side.st;
            p_calc_reg[0] <= r_side.calc;
            p_sat_reg[0]  <= s_wd1 | s_wd2 | s_wv1 | s_wv2;
            for (int i = 1; i < 5; i++) begin
                p_st_reg[i]   <= p_st_reg[i-1];
                p_calc_reg[i] <= p_calc_reg[i-1];
            end
            p_sat_reg[1] <= p_sat_reg[0];
            p_sat_reg[2] <= p_sat_reg[1] | f1_s.sat | f2_s.sat;
            p_sat_reg[3] <= p_sat_reg[2];
            p_sat_reg[4] <= p_sat_reg[3] | f_s.sat;

            p1_wd1_reg <= wd1;
            p1_wd2_reg <= wd2;
            p1_wv1_reg <= wv1;
            p1_wv2_reg <= wv2;

            p2_wd1_reg <= p1_wd1_reg;
            p2_wd2_reg <= p1_wd2_reg;
            p2_m11_reg <= 64'(p1_wv1_reg) * 64'($signed(t11));
            p2_m21_reg <= 64'(p1_wv2_reg) * 64'($signed(t21));
            p2_m12_reg <= 64'(p1_wv1_reg) * 64'($signed(t12));
            p2_m22_reg <= 64'(p1_wv2_reg) * 64'($signed(t22));

            p3_wd1_reg <= p2_wd1_reg;
            p3_wd2_reg <= p2_wd2_reg;
            p3_f1_reg  <= f1_s.val;
            p3_f2_reg  <= f2_s.val;

            p4_m1_reg <= 64'(p3_wd1_reg) * 64'(p3_f1_reg);
            p4_m2_reg <= 64'(p3_wd2_reg) * 64'(p3_f2_reg);

            p5_f_reg <= f_s.val;
        end
    end

    // Result register.
    logic        m_tvalid_reg;
    logic [31:0] m_tdata_reg;
    logic [1:0]  m_tuser_reg;

    assign en = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= p_valid_reg[4];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (p_calc_reg[4]) begin
                m_tdata_reg <= res_s.val;
                m_tuser_reg <= (p_sat_reg[4] || res_s.sat) ? ST_SAT : ST_OK;
            end else begin
                m_tdata_reg <= '0;
                m_tuser_reg <= p_st_reg[4];
            end
        end
    end

    assign s_tready = en;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
